// ----- hw/rtl/bhgm_pkg.sv -----
// ----------------------------------------------------------------------------
// Body height grid map package
// Shared widths, register indexes, codes and types of the height grid map.
// ----------------------------------------------------------------------------
package bhgm_pkg;

   localparam int BOX_W      = 12;
   localparam int HEIGHT_W   = 20;
   localparam int TALLY_W    = 9;
   localparam int CELL_W     = 1 + TALLY_W + HEIGHT_W;
   localparam int DIV_W      = 30;
   localparam int VERDICT_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TALLY_W-1:0] TALLY_MAX = 9'd511;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_SIGMA = 3'd4;

   localparam logic [VERDICT_W-1:0] VERDICT_NOT_SURE = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_GOOD     = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_BAD      = 2'd2;

   localparam logic ACTION_VOTE  = 1'b0;
   localparam logic ACTION_CHECK = 1'b1;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [7:0]  count_limit;
      logic [15:0] learn_rate;
      logic [15:0] height_sigma;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW_DIV,
      ST_COL_DIV,
      ST_CELL_RD,
      ST_CELL_EVAL,
      ST_CELL_MUL,
      ST_CELL_FIN,
      ST_CELL_DIV,
      ST_CELL_WR,
      ST_CHK_RD,
      ST_CHK_EVAL,
      ST_CHK_MUL1,
      ST_CHK_MUL2,
      ST_CHK_OUT
   } state_type;

   typedef enum logic [1:0] {
      MODE_SET,
      MODE_BLEND,
      MODE_MEAN
   } mode_type;

endpackage

// ----- hw/rtl/bhgm_req_if.sv -----
// ----------------------------------------------------------------------------
// Body height grid map request channel
// Valid/ready channel that carries one box item.
// ----------------------------------------------------------------------------
interface bhgm_req_if;
   import bhgm_pkg::*;

   logic               valid;
   logic               ready;
   logic               action;
   logic [BOX_W-1:0]   box_x;
   logic [BOX_W-1:0]   box_y;
   logic [BOX_W-1:0]   box_width;
   logic [BOX_W-1:0]   box_height;

   modport source (output valid, action, box_x, box_y, box_width, box_height,
                   input ready);
   modport sink   (input valid, action, box_x, box_y, box_width, box_height,
                   output ready);
endinterface

// ----- hw/rtl/bhgm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Body height grid map response channel
// Valid/ready channel that carries one verdict.
// ----------------------------------------------------------------------------
interface bhgm_rsp_if;
   import bhgm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;

   modport source (output valid, verdict, input ready);
   modport sink   (input valid, verdict, output ready);
endinterface

// ----- hw/rtl/bhgm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhgm_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- hw/rtl/bhgm_div.sv -----
// ----------------------------------------------------------------------------
// Body height grid map divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bhgm_div #(
   parameter int DW = 30
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CNT_W = $clog2(DW + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DW - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DW:0]      rem_ff;
   logic [DW-1:0]    quo_ff;
   logic [DW-1:0]    den_ff;
   logic [DW:0]      shifted;
   logic [DW:0]      diff;
   logic [DW:0]      rem_in;
   logic [DW-1:0]    quo_in;

   always_comb begin
      shifted = {rem_ff[DW-1:0], quo_ff[DW-1]};
      diff    = shifted - {1'b0, den_ff};
      if (!diff[DW]) begin
         rem_in = diff;
         quo_in = {quo_ff[DW-2:0], 1'b1};
      end else begin
         rem_in = shifted;
         quo_in = {quo_ff[DW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- hw/rtl/bhgm_csr.sv -----
// ----------------------------------------------------------------------------
// Body height grid map configuration registers
// Write-only register file for frame size, vote limit and learning weights.
// ----------------------------------------------------------------------------
module bhgm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             we,
   input  logic [bhgm_pkg::CSR_IDX_W-1:0]  index,
   input  logic [bhgm_pkg::CSR_DATA_W-1:0] wdata,
   output bhgm_pkg::cfg_type                cfg
);
   import bhgm_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 12'd640;
         cfg_ff.frame_height <= 12'd480;
         cfg_ff.count_limit  <= 8'd10;
         cfg_ff.learn_rate   <= 16'd6554;
         cfg_ff.height_sigma <= 16'd6554;
      end else if (we) begin
         unique case (index)
            CSR_FRAME_WIDTH:  cfg_ff.frame_width  <= wdata[11:0];
            CSR_FRAME_HEIGHT: cfg_ff.frame_height <= wdata[11:0];
            CSR_COUNT_LIMIT:  cfg_ff.count_limit  <= wdata[7:0];
            CSR_LEARN_RATE:   cfg_ff.learn_rate   <= wdata;
            CSR_HEIGHT_SIGMA: cfg_ff.height_sigma <= wdata;
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

// ----- hw/rtl/body_height_grid_map.sv -----
// ----------------------------------------------------------------------------
// Body height grid map
// Learns person heights per grid cell from voted boxes and checks new boxes
// against the learned height of the cell under their foot point.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                   Transfer
//   req_if    in         action, box_x, box_y, box_width, box_height valid & ready
//   rsp_if    out        verdict                                   valid & ready
//   csr_*     in         csr_index, csr_wdata                      csr_we
//
// After reset a clearing pass writes every cell to zero, one cell per cycle,
// and no request is taken during it. Every item first finds its cell with two
// divisions on a shared bit-serial divider. A check then reads one cell. A
// vote does nine read-modify-writes of the cell store in order; a cell in
// running-mean mode needs one more division. One item is in flight at a time.
// A finished verdict sits in an output register, so a stalled response only
// holds the next check at its last step; votes go on meanwhile.
// ----------------------------------------------------------------------------
module body_height_grid_map #(
   parameter int GRID_ROWS = 8,
   parameter int GRID_COLS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   bhgm_req_if.sink                         req_if,
   bhgm_rsp_if.source                       rsp_if,
   input  logic                             csr_we,
   input  logic [bhgm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bhgm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bhgm_pkg::*;

   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(GRID_ROWS);
   localparam int CW    = $clog2(GRID_COLS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [RW-1:0] LAST_ROW  = RW'(GRID_ROWS - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(GRID_COLS - 1);

   cfg_type cfg;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff;

   // Item being worked on.
   logic             act_ff;
   logic [BOX_W-1:0] bx_ff, bw_ff, bh_ff;
   logic [RW-1:0]    row_ff;
   logic [CW-1:0]    col_ff;
   logic [1:0]       di_ff, dj_ff;

   // Cell under work and its new contents.
   logic                cur_known_ff;
   logic [TALLY_W-1:0]  cur_tally_ff;
   logic [HEIGHT_W-1:0] cur_height_ff;
   logic [HEIGHT_W-1:0] new_height_ff;
   mode_type            mode_ff;
   logic [35:0]         prod_a_ff;
   logic [46:0]         prod_b_ff;

   logic                 rsp_valid_ff;
   logic [VERDICT_W-1:0] rsp_verdict_ff;

   // Divider and memory hookup.
   logic             div_start, div_done;
   logic [DIV_W-1:0] div_dividend, div_divisor, div_quo;
   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   logic                rd_known;
   logic [TALLY_W-1:0]  rd_tally;
   logic [HEIGHT_W-1:0] rd_height;

   logic [11:0]         fw_eff, fh_eff;
   logic [HEIGHT_W-1:0] h256;
   logic [RW-1:0]       row_clamp, r_sel;
   logic [CW-1:0]       col_clamp, c_sel;
   logic [AW-1:0]       cell_addr;
   logic                last_nbr;
   logic                rsp_free;

   logic [16:0]         inv_lr;
   logic [TALLY_W-1:0]  tally_m1;
   logic [HEIGHT_W-1:0] diff;
   logic [10:0]         k_fac;
   logic [35:0]         mul_lr_h;
   logic [36:0]         mul_inv_c;
   logic [28:0]         mul_n_c;
   logic [28:0]         mul_d_n;
   logic [26:0]         mul_k_s;
   logic [46:0]         mul_t_c;
   logic [37:0]         blend_sum;
   logic [46:0]         lhs;
   logic [VERDICT_W-1:0] verdict;

   bhgm_csr u_csr (
      .clock (clock),
      .reset (reset),
      .we    (csr_we),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   bhgm_div #(.DW(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Each word holds the known flag, the vote tally and the Q12.8 height.
   bhgm_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_known  = ram_rdata[CELL_W-1];
   assign rd_tally  = ram_rdata[HEIGHT_W +: TALLY_W];
   assign rd_height = ram_rdata[HEIGHT_W-1:0];

   // A zero frame size counts as one pixel.
   assign fw_eff = (cfg.frame_width == 12'd0) ? 12'd1 : cfg.frame_width;
   assign fh_eff = (cfg.frame_height == 12'd0) ? 12'd1 : cfg.frame_height;
   assign h256   = {bh_ff, 8'd0};

   // Feet beyond the frame land on the last row or column.
   assign row_clamp = (div_quo > DIV_W'(GRID_ROWS - 1)) ? LAST_ROW : div_quo[RW-1:0];
   assign col_clamp = (div_quo > DIV_W'(GRID_COLS - 1)) ? LAST_COL : div_quo[CW-1:0];

   // Neighbor offsets are clamped at the grid border, so border cells may be
   // visited more than once by one vote.
   always_comb begin
      unique case (di_ff)
         2'd0:    r_sel = (row_ff == '0) ? row_ff : row_ff - RW'(1);
         2'd1:    r_sel = row_ff;
         default: r_sel = (row_ff == LAST_ROW) ? row_ff : row_ff + RW'(1);
      endcase
      unique case (dj_ff)
         2'd0:    c_sel = (col_ff == '0) ? col_ff : col_ff - CW'(1);
         2'd1:    c_sel = col_ff;
         default: c_sel = (col_ff == LAST_COL) ? col_ff : col_ff + CW'(1);
      endcase
   end

   assign cell_addr = AW'(r_sel) * AW'(GRID_COLS) + AW'(c_sel);
   assign last_nbr  = (di_ff == 2'd2) && (dj_ff == 2'd2);
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;

   // Products, each used in one state and registered before the next step.
   assign inv_lr    = 17'h10000 - {1'b0, cfg.learn_rate};
   assign tally_m1  = cur_tally_ff - TALLY_W'(1);
   assign diff      = (cur_height_ff > h256) ? cur_height_ff - h256 : h256 - cur_height_ff;
   assign k_fac     = {2'd0, cur_tally_ff} * 11'd3 + 11'd10;
   assign mul_lr_h  = 36'(cfg.learn_rate) * 36'(h256);
   assign mul_inv_c = 37'(inv_lr) * 37'(cur_height_ff);
   assign mul_n_c   = 29'(tally_m1) * 29'(cur_height_ff);
   assign mul_d_n   = 29'(diff) * 29'(cur_tally_ff);
   assign mul_k_s   = 27'(k_fac) * 27'(cfg.height_sigma);
   assign mul_t_c   = 47'(prod_b_ff[26:0]) * 47'(cur_height_ff);
   assign blend_sum = 38'(prod_a_ff) + 38'(prod_b_ff[36:0]) + 38'd32768;

   // Good when |cell - h| * n * 2^16 < (3n + 10) * sigma * cell.
   assign lhs = 47'({prod_a_ff[28:0], 16'd0});
   always_comb begin
      if (!cur_known_ff) begin
         verdict = VERDICT_NOT_SURE;
      end else if (lhs < prod_b_ff) begin
         verdict = VERDICT_GOOD;
      end else begin
         verdict = VERDICT_BAD;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (clr_ff == LAST_CELL) state_in = ST_IDLE;
         ST_IDLE:      if (req_if.valid) state_in = ST_ROW_DIV;
         ST_ROW_DIV:   if (div_done) state_in = ST_COL_DIV;
         ST_COL_DIV: begin
            if (div_done) state_in = (act_ff == ACTION_CHECK) ? ST_CHK_RD : ST_CELL_RD;
         end
         ST_CELL_RD:   state_in = ST_CELL_EVAL;
         ST_CELL_EVAL: state_in = rd_known ? ST_CELL_MUL : ST_CELL_WR;
         ST_CELL_MUL:  state_in = ST_CELL_FIN;
         ST_CELL_FIN:  state_in = (mode_ff == MODE_MEAN) ? ST_CELL_DIV : ST_CELL_WR;
         ST_CELL_DIV:  if (div_done) state_in = ST_CELL_WR;
         ST_CELL_WR:   state_in = last_nbr ? ST_IDLE : ST_CELL_RD;
         ST_CHK_RD:    state_in = ST_CHK_EVAL;
         ST_CHK_EVAL:  state_in = ST_CHK_MUL1;
         ST_CHK_MUL1:  state_in = ST_CHK_MUL2;
         ST_CHK_MUL2:  state_in = ST_CHK_OUT;
         ST_CHK_OUT:   if (rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_if.ready = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      ram_re       = 1'b0;
      ram_raddr    = cell_addr;
      ram_we       = 1'b0;
      ram_waddr    = cell_addr;
      ram_wdata    = {1'b1, cur_tally_ff, new_height_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            req_if.ready = 1'b1;
            div_start    = req_if.valid;
            div_dividend = DIV_W'(13'(req_if.box_y) + 13'(req_if.box_height))
                           * DIV_W'(GRID_ROWS);
            div_divisor  = DIV_W'(fh_eff);
         end
         ST_ROW_DIV: begin
            div_start    = div_done;
            div_dividend = DIV_W'(14'({bx_ff, 1'b0}) + 14'(bw_ff)) * DIV_W'(GRID_COLS);
            div_divisor  = DIV_W'({fw_eff, 1'b0});
         end
         ST_CELL_FIN: begin
            div_start    = (mode_ff == MODE_MEAN);
            div_dividend = DIV_W'(prod_a_ff[28:0]) + DIV_W'(h256)
                           + DIV_W'(cur_tally_ff[TALLY_W-1:1]);
            div_divisor  = DIV_W'(cur_tally_ff);
         end
         ST_CELL_RD, ST_CHK_RD: ram_re = 1'b1;
         ST_CELL_WR:            ram_we = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               act_ff <= req_if.action;
               bx_ff  <= req_if.box_x;
               bw_ff  <= req_if.box_width;
               bh_ff  <= req_if.box_height;
            end
         end
         ST_ROW_DIV: if (div_done) row_ff <= row_clamp;
         ST_COL_DIV: begin
            if (div_done) begin
               col_ff <= col_clamp;
               // A check looks only at the center cell.
               di_ff  <= (act_ff == ACTION_CHECK) ? 2'd1 : 2'd0;
               dj_ff  <= (act_ff == ACTION_CHECK) ? 2'd1 : 2'd0;
            end
         end
         ST_CELL_EVAL: begin
            cur_height_ff <= rd_height;
            if (!rd_known) begin
               mode_ff       <= MODE_SET;
               new_height_ff <= h256;
               cur_tally_ff  <= (rd_tally == TALLY_MAX) ? rd_tally : rd_tally + TALLY_W'(1);
            end else if (rd_tally > {1'b0, cfg.count_limit}) begin
               mode_ff      <= MODE_BLEND;
               cur_tally_ff <= rd_tally;
            end else begin
               mode_ff      <= MODE_MEAN;
               cur_tally_ff <= (rd_tally == TALLY_MAX) ? rd_tally : rd_tally + TALLY_W'(1);
            end
         end
         ST_CELL_MUL: begin
            if (mode_ff == MODE_BLEND) begin
               prod_a_ff <= mul_lr_h;
               prod_b_ff <= 47'(mul_inv_c);
            end else begin
               prod_a_ff <= 36'(mul_n_c);
            end
         end
         ST_CELL_FIN: begin
            if (mode_ff == MODE_BLEND) new_height_ff <= blend_sum[35:16];
         end
         ST_CELL_DIV: if (div_done) new_height_ff <= div_quo[HEIGHT_W-1:0];
         ST_CELL_WR: begin
            if (dj_ff == 2'd2) begin
               dj_ff <= 2'd0;
               di_ff <= di_ff + 2'd1;
            end else begin
               dj_ff <= dj_ff + 2'd1;
            end
         end
         ST_CHK_EVAL: begin
            cur_known_ff  <= rd_known;
            cur_tally_ff  <= rd_tally;
            cur_height_ff <= rd_height;
         end
         ST_CHK_MUL1: begin
            prod_a_ff <= 36'(mul_d_n);
            prod_b_ff <= 47'(mul_k_s);
         end
         ST_CHK_MUL2: prod_b_ff <= mul_t_c;
         default: begin
         end
      endcase
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_CHK_OUT) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_CHK_OUT) && rsp_free) rsp_verdict_ff <= verdict;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.verdict = rsp_verdict_ff;
endmodule

// ----- hw/rtl/bhgm_chk.sv -----
// ----------------------------------------------------------------------------
// Body height grid map port checker
// Watches the channel ports of the grid map over time.
// ----------------------------------------------------------------------------
module bhgm_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [bhgm_pkg::VERDICT_W-1:0] rsp_verdict
);
   import bhgm_pkg::*;

   // A pending response stays until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_verdict))
      else $error("response changed while stalled");

   // The cell store is being cleared right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   // One item at a time: taking an item closes the request side.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken back to back");
endmodule

bind body_height_grid_map bhgm_chk u_bhgm_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_verdict (rsp_if.verdict)
);
